[design/johnson_cook_damage_update_assert.svh]
// assertion macros for the damage update block
`ifndef JOHNSON_COOK_DAMAGE_UPDATE_ASSERT_SVH
`define JOHNSON_COOK_DAMAGE_UPDATE_ASSERT_SVH

// ante implies cons in the same cycle
`define JCDU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond never holds
`define JCDU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[design/jcdu_pkg.sv]
`timescale 1ns / 1ps

package jcdu_pkg;

    typedef struct packed {
        logic               already_failed;
        logic        [24:0] old_damage;
        logic signed [31:0] mean_stress;
        logic        [30:0] equivalent_stress;
        logic signed [31:0] log_strain_rate;
        logic signed [31:0] temp_star;
        logic signed [31:0] plastic_strain_inc;
    } t_item;

    typedef struct packed {
        logic [24:0] new_damage;
        logic [30:0] stress_scale;
        logic        failed;
        logic        eroded;
    } t_result;

    typedef enum logic [2:0] {
        CFG_D1      = 3'd0,
        CFG_D2      = 3'd1,
        CFG_D3      = 3'd2,
        CFG_D4      = 3'd3,
        CFG_D5      = 3'd4,
        CFG_EROSION = 3'd5,
        CFG_EPSILON = 3'd6
    } t_cfg_idx;

    // context carried alongside each particle
    typedef struct packed {
        logic               was_failed;
        logic        [24:0] dmg_in;
        logic signed [31:0] mean;
        logic        [30:0] equiv;
        logic signed [31:0] lrate;
        logic signed [31:0] theta;
        logic signed [31:0] dstrain;
        logic signed [31:0] frate;
        logic signed [31:0] ftemp;
        logic signed [31:0] triax;
        logic signed [31:0] term;
        logic signed [31:0] frac;
        logic signed [9:0]  exp_n;
        logic        [29:0] exp_r;
        logic        [31:0] acc;
        logic               neg;
        logic               go;
        logic        [24:0] prior;
        logic        [24:0] dmg_new;
    } t_ctx;

    localparam logic signed [31:0] Q_ONE     = 32'sd16777216;
    localparam logic signed [31:0] Q_MAX     = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
    localparam logic        [24:0] DMG_ONE   = 25'd16777216;
    localparam logic        [30:0] SCALE_ONE = 31'd16777216;
    localparam logic        [30:0] SCALE_MAX = 31'h7fff_ffff;

    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] EXP_CQ    = (64'd1 << 37) / LN2_Q30;
    localparam logic [63:0] EXP_OFS   = LN2_Q30 - ((64'd1 << 37) - EXP_CQ * LN2_Q30);
    localparam logic [63:0] EXP_RECIP = (64'd1 << 40) / LN2_Q30;
    localparam logic [63:0] EXP_BIAS  = EXP_CQ + 64'd1;

    localparam int HORNER_TERMS = 14;
    localparam int DIV1_NW = 56;
    localparam int DIV1_DW = 32;
    localparam int DIV1_QW = 32;
    localparam int DIV2_NW = 56;
    localparam int DIV2_DW = 31;
    localparam int DIV2_QW = 26;
    localparam int DIV3_NW = 49;
    localparam int DIV3_DW = 25;
    localparam int DIV3_QW = 31;

    localparam int LATENCY = 3 + (DIV1_QW + 1) + 6 + 3 * HORNER_TERMS + 7
                           + (DIV2_QW + 1) + 1 + (DIV3_QW + 1) + 1;

    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 24;
        if (s > 64'sd2147483647) begin
            return Q_MAX;
        end else if (s < -64'sd2147483648) begin
            return Q_MIN;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? Q_MIN : Q_MAX;
        end
        return s[31:0];
    endfunction

endpackage

[design/jcdu_div.sv]
`timescale 1ns / 1ps

module jcdu_div #(
    parameter int NW = jcdu_pkg::DIV1_NW,
    parameter int DW = jcdu_pkg::DIV1_DW,
    parameter int QW = jcdu_pkg::DIV1_QW,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic          o_ovf,
    output logic [TW-1:0] o_tag
);

    logic          r_vld [0:QW];
    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_lo  [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic          r_ovf [0:QW];
    logic [TW-1:0] r_tag [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= DW'(i_num[NW-1:QW]);
        r_lo[0]  <= i_num[QW-1:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_ovf[0] <= DW'(i_num[NW-1:QW]) >= i_den;
        r_tag[0] <= i_tag;
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [DW:0] w_trial;
        logic        w_fit;

        always_comb begin
            w_trial = {r_rem[s], r_lo[s][QW-1]};
            w_fit   = w_trial >= {1'b0, r_den[s]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= w_fit ? DW'(w_trial - {1'b0, r_den[s]}) : w_trial[DW-1:0];
            r_lo[s+1]  <= r_lo[s] << 1;
            r_q[s+1]   <= {r_q[s][QW-2:0], w_fit};
            r_den[s+1] <= r_den[s];
            r_ovf[s+1] <= r_ovf[s];
            r_tag[s+1] <= r_tag[s];
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_q[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_tag   = r_tag[QW];

endmodule

[design/johnson_cook_damage_update.sv]
`timescale 1ns / 1ps

// Johnson-Cook damage update, one particle word per cycle, signed Q8.24.
// Input: drive start high with a word on i_item; it is taken at the clock
// edge where start is high and busy is low. busy stays low, so a new word
// can be taken on every cycle.
// Output: o_done pulses for one cycle with the matching o_result; the
// receiver cannot hold results off and none is needed, the pipeline never
// stalls. Results come out in input order.
// Throughput is one word per cycle. The depth is set by three
// bit-per-stage dividers (triaxiality, damage increment, stress
// scale) and the 14-term exp series, three stages per term.
// Configuration: i_cfg_valid with i_cfg_index / i_cfg_data writes one
// register per cycle, o_cfg_ready is always high. Write it only while no
// word is in flight.
// Reset (synchronous, i_rst_n low) clears all in-flight words and sets
// the coefficients to zero, erosion off and epsilon to one LSB.

module johnson_cook_damage_update (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  jcdu_pkg::t_item     i_item,
    output logic                busy,
    output logic                o_done,
    output jcdu_pkg::t_result   o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int HT  = jcdu_pkg::HORNER_TERMS;
    localparam int CTW = $bits(jcdu_pkg::t_ctx);

    logic signed [31:0] r_coef_d1, r_coef_d2, r_coef_d3, r_coef_d4, r_coef_d5;
    logic               r_erosion_on;
    logic        [30:0] r_epsilon;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_d1    <= '0;
            r_coef_d2    <= '0;
            r_coef_d3    <= '0;
            r_coef_d4    <= '0;
            r_coef_d5    <= '0;
            r_erosion_on <= 1'b0;
            r_epsilon    <= 31'd1;
        end else if (i_cfg_valid) begin
            case (jcdu_pkg::t_cfg_idx'(i_cfg_index))
                jcdu_pkg::CFG_D1: begin
                    r_coef_d1 <= $signed(i_cfg_data);
                end
                jcdu_pkg::CFG_D2: begin
                    r_coef_d2 <= $signed(i_cfg_data);
                end
                jcdu_pkg::CFG_D3: begin
                    r_coef_d3 <= $signed(i_cfg_data);
                end
                jcdu_pkg::CFG_D4: begin
                    r_coef_d4 <= $signed(i_cfg_data);
                end
                jcdu_pkg::CFG_D5: begin
                    r_coef_d5 <= $signed(i_cfg_data);
                end
                jcdu_pkg::CFG_EROSION: begin
                    r_erosion_on <= i_cfg_data[0];
                end
                jcdu_pkg::CFG_EPSILON: begin
                    r_epsilon <= i_cfg_data[30:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: input word, rate and temperature factors
    logic                  r_in_vld, r_q1_vld, r_q2_vld;
    jcdu_pkg::t_item       r_in;
    jcdu_pkg::t_ctx        r_q1_ctx, r_q2_ctx, n_q1_ctx;
    logic signed [63:0]    r_q1_pr, r_q1_pt;

    always_comb begin
        n_q1_ctx            = '0;
        n_q1_ctx.was_failed = r_in.already_failed;
        n_q1_ctx.dmg_in     = r_in.old_damage;
        n_q1_ctx.mean       = r_in.mean_stress;
        n_q1_ctx.equiv      = r_in.equivalent_stress;
        n_q1_ctx.lrate      = r_in.log_strain_rate;
        n_q1_ctx.theta      = r_in.temp_star;
        n_q1_ctx.dstrain    = r_in.plastic_strain_inc;
    end

    always_ff @(posedge i_clk) begin
        r_in     <= i_item;
        r_q1_ctx <= n_q1_ctx;
        r_q1_pr  <= $signed(r_coef_d4) * $signed(r_in.log_strain_rate);
        r_q1_pt  <= $signed(r_coef_d5) * $signed(r_in.temp_star);
        r_q2_ctx       <= r_q1_ctx;
        r_q2_ctx.frate <= jcdu_pkg::add_sat(jcdu_pkg::Q_ONE, jcdu_pkg::qsat(r_q1_pr));
        r_q2_ctx.ftemp <= jcdu_pkg::add_sat(jcdu_pkg::Q_ONE, jcdu_pkg::qsat(r_q1_pt));
    end

    // triaxiality divider
    jcdu_pkg::t_ctx n_d1_tag, w_d1_tag;
    logic [31:0]    w_d1_mabs, w_d1_den, w_d1_q;
    logic           w_d1_vld, w_d1_ovf;

    always_comb begin
        w_d1_mabs    = r_q2_ctx.mean[31] ? (~r_q2_ctx.mean + 32'd1) : r_q2_ctx.mean;
        w_d1_den     = {1'b0, r_q2_ctx.equiv} + {1'b0, r_epsilon};
        n_d1_tag     = r_q2_ctx;
        n_d1_tag.neg = r_q2_ctx.mean[31];
    end

    jcdu_div #(
        .NW(jcdu_pkg::DIV1_NW), .DW(jcdu_pkg::DIV1_DW), .QW(jcdu_pkg::DIV1_QW), .TW(CTW)
    ) u_div_triax (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_q2_vld),
        .i_num({w_d1_mabs, 24'd0}), .i_den(w_d1_den), .i_tag(n_d1_tag),
        .o_valid(w_d1_vld), .o_quot(w_d1_q), .o_ovf(w_d1_ovf), .o_tag(w_d1_tag)
    );

    // triaxiality, exponent argument, range reduction
    logic               r_t1_vld, r_t2_vld, r_t3_vld, r_e1_vld, r_e2_vld, r_e3_vld;
    jcdu_pkg::t_ctx     r_t1_ctx, r_t2_ctx, r_t3_ctx, r_e1_ctx, r_e2_ctx, r_e3_ctx;
    logic signed [31:0] n_triax, w_x;
    logic signed [63:0] r_t2_p;
    logic [38:0]        r_t3_v, r_e1_v, w_v;
    logic [9:0]         r_e1_q0, r_e2_q0, w_q;
    logic [30:0]        r_e2_rr, w_rr;
    logic [10:0]        w_n;

    always_comb begin
        if (w_d1_tag.equiv == '0 && r_epsilon == '0) begin
            if (w_d1_tag.mean > 32'sd0) begin
                n_triax = jcdu_pkg::Q_MAX;
            end else if (w_d1_tag.mean < 32'sd0) begin
                n_triax = jcdu_pkg::Q_MIN;
            end else begin
                n_triax = '0;
            end
        end else if (!w_d1_tag.neg) begin
            n_triax = (w_d1_ovf || w_d1_q[31]) ? jcdu_pkg::Q_MAX : $signed(w_d1_q);
        end else begin
            n_triax = (w_d1_ovf || w_d1_q > 32'h8000_0000) ? jcdu_pkg::Q_MIN
                                                            : $signed(~w_d1_q + 32'd1);
        end
        w_x = jcdu_pkg::qsat(r_t2_p);
        w_v = {1'b0, ~w_x[31], w_x[30:0], 6'd0} + 39'(jcdu_pkg::EXP_OFS);
        if (r_e2_rr >= 31'(jcdu_pkg::LN2_Q30)) begin
            w_q  = r_e2_q0 + 10'd1;
            w_rr = r_e2_rr - 31'(jcdu_pkg::LN2_Q30);
        end else begin
            w_q  = r_e2_q0;
            w_rr = r_e2_rr;
        end
        w_n = {1'b0, w_q} - 11'(jcdu_pkg::EXP_BIAS);
    end

    always_ff @(posedge i_clk) begin
        r_t1_ctx       <= w_d1_tag;
        r_t1_ctx.triax <= n_triax;
        r_t2_ctx       <= r_t1_ctx;
        r_t2_p         <= $signed(r_coef_d3) * $signed(r_t1_ctx.triax);
        r_t3_ctx       <= r_t2_ctx;
        r_t3_v         <= w_v;
        r_e1_ctx       <= r_t3_ctx;
        r_e1_v         <= r_t3_v;
        r_e1_q0        <= 10'((50'(r_t3_v) * 50'(jcdu_pkg::EXP_RECIP)) >> 40);
        r_e2_ctx       <= r_e1_ctx;
        r_e2_q0        <= r_e1_q0;
        r_e2_rr        <= 31'(40'(r_e1_v) - 40'(r_e1_q0) * 40'(jcdu_pkg::LN2_Q30));
        r_e3_ctx       <= r_e2_ctx;
        r_e3_ctx.exp_n <= $signed(w_n[9:0]);
        r_e3_ctx.exp_r <= w_rr[29:0];
        r_e3_ctx.acc   <= 32'(jcdu_pkg::ONE_Q30);
    end

    // exp series, three stages per term
    logic           w_h_vld [0:HT];
    jcdu_pkg::t_ctx w_h_ctx [0:HT];

    assign w_h_vld[0] = r_e3_vld;
    assign w_h_ctx[0] = r_e3_ctx;

    for (genvar j = 0; j < HT; j++) begin : g_horner
        localparam logic [3:0]  K     = 4'(HT - j);
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / (HT - j));

        logic           r_a_vld, r_b_vld, r_c_vld;
        jcdu_pkg::t_ctx r_a_ctx, r_b_ctx, r_c_ctx;
        logic [31:0]    r_a_t, r_b_t, r_b_q, w_q1;
        logic [35:0]    w_rem;

        always_comb begin
            w_rem = 36'(r_b_t) - 36'(r_b_q) * 36'(K);
            w_q1  = (w_rem >= 36'(K)) ? r_b_q + 32'd1 : r_b_q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld <= 1'b0;
                r_b_vld <= 1'b0;
                r_c_vld <= 1'b0;
            end else begin
                r_a_vld <= w_h_vld[j];
                r_b_vld <= r_a_vld;
                r_c_vld <= r_b_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_a_ctx     <= w_h_ctx[j];
            r_a_t       <= 32'((62'(w_h_ctx[j].acc) * 62'(w_h_ctx[j].exp_r)) >> 30);
            r_b_ctx     <= r_a_ctx;
            r_b_t       <= r_a_t;
            r_b_q       <= 32'((65'(r_a_t) * 65'(RECIP)) >> 32);
            r_c_ctx     <= r_b_ctx;
            r_c_ctx.acc <= 32'(jcdu_pkg::ONE_Q30) + w_q1;
        end

        assign w_h_vld[j+1] = r_c_vld;
        assign w_h_ctx[j+1] = r_c_ctx;
    end

    // scale back, then fracture strain
    logic               r_x1_vld, r_x2_vld, r_x3_vld, r_x4_vld, r_x5_vld, r_x6_vld, r_x7_vld;
    jcdu_pkg::t_ctx     r_x1_ctx, r_x2_ctx, r_x3_ctx, r_x4_ctx, r_x5_ctx, r_x6_ctx, r_x7_ctx;
    jcdu_pkg::t_ctx     w_hx;
    logic signed [31:0] r_x1_e, n_x1_e, r_x5_a, w_frac;
    logic signed [63:0] r_x2_m, r_x4_m, r_x6_m;
    logic signed [10:0] w_sh;
    logic [31:0]        w_shifted;

    always_comb begin
        w_hx      = w_h_ctx[HT];
        w_sh      = 11'sd6 - 11'(w_hx.exp_n);
        w_shifted = w_hx.acc >> w_sh[5:0];
        if (w_hx.exp_n > 10'sd6) begin
            n_x1_e = jcdu_pkg::Q_MAX;
        end else if (w_sh > 11'sd62) begin
            n_x1_e = '0;
        end else if (w_shifted[31]) begin
            n_x1_e = jcdu_pkg::Q_MAX;
        end else begin
            n_x1_e = $signed(w_shifted);
        end
        w_frac = jcdu_pkg::qsat(r_x6_m);
    end

    always_ff @(posedge i_clk) begin
        r_x1_ctx       <= w_hx;
        r_x1_e         <= n_x1_e;
        r_x2_ctx       <= r_x1_ctx;
        r_x2_m         <= $signed(r_coef_d2) * $signed(r_x1_e);
        r_x3_ctx       <= r_x2_ctx;
        r_x3_ctx.term  <= jcdu_pkg::add_sat(r_coef_d1, jcdu_pkg::qsat(r_x2_m));
        r_x4_ctx       <= r_x3_ctx;
        r_x4_m         <= $signed(r_x3_ctx.term) * $signed(r_x3_ctx.frate);
        r_x5_ctx       <= r_x4_ctx;
        r_x5_a         <= jcdu_pkg::qsat(r_x4_m);
        r_x6_ctx       <= r_x5_ctx;
        r_x6_m         <= $signed(r_x5_a) * $signed(r_x5_ctx.ftemp);
        r_x7_ctx       <= r_x6_ctx;
        r_x7_ctx.frac  <= w_frac;
        r_x7_ctx.go    <= !r_x6_ctx.was_failed && (w_frac > $signed({1'b0, r_epsilon}));
        r_x7_ctx.prior <= (r_x6_ctx.dmg_in > jcdu_pkg::DMG_ONE) ? jcdu_pkg::DMG_ONE
                                                                : r_x6_ctx.dmg_in;
    end

    // damage increment divider
    jcdu_pkg::t_ctx n_d2_tag, w_d2_tag;
    logic [31:0]    w_d2_sabs;
    logic [25:0]    w_d2_q;
    logic           w_d2_vld, w_d2_ovf;

    always_comb begin
        w_d2_sabs    = r_x7_ctx.dstrain[31] ? (~r_x7_ctx.dstrain + 32'd1) : r_x7_ctx.dstrain;
        n_d2_tag     = r_x7_ctx;
        n_d2_tag.neg = r_x7_ctx.dstrain[31];
    end

    jcdu_div #(
        .NW(jcdu_pkg::DIV2_NW), .DW(jcdu_pkg::DIV2_DW), .QW(jcdu_pkg::DIV2_QW), .TW(CTW)
    ) u_div_inc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_x7_vld),
        .i_num({w_d2_sabs, 24'd0}), .i_den(r_x7_ctx.frac[30:0]), .i_tag(n_d2_tag),
        .o_valid(w_d2_vld), .o_quot(w_d2_q), .o_ovf(w_d2_ovf), .o_tag(w_d2_tag)
    );

    // new damage
    logic               r_u1_vld;
    jcdu_pkg::t_ctx     r_u1_ctx;
    logic [26:0]        w_imag;
    logic signed [27:0] w_sum;
    logic [24:0]        n_dmg;

    always_comb begin
        w_imag = w_d2_ovf ? 27'h400_0000 : {1'b0, w_d2_q};
        w_sum  = w_d2_tag.neg ? $signed({3'd0, w_d2_tag.prior}) - $signed({1'b0, w_imag})
                              : $signed({3'd0, w_d2_tag.prior}) + $signed({1'b0, w_imag});
        if (w_d2_tag.prior >= jcdu_pkg::DMG_ONE) begin
            n_dmg = w_d2_tag.prior;
        end else if (w_sum < 28'sd0) begin
            n_dmg = '0;
        end else if (w_sum > $signed({3'd0, jcdu_pkg::DMG_ONE})) begin
            n_dmg = jcdu_pkg::DMG_ONE;
        end else begin
            n_dmg = w_sum[24:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_u1_ctx         <= w_d2_tag;
        r_u1_ctx.dmg_new <= n_dmg;
    end

    // stress scale divider
    jcdu_pkg::t_ctx w_d3_tag;
    logic [30:0]    w_d3_q;
    logic           w_d3_vld, w_d3_ovf;

    jcdu_div #(
        .NW(jcdu_pkg::DIV3_NW), .DW(jcdu_pkg::DIV3_DW), .QW(jcdu_pkg::DIV3_QW), .TW(CTW)
    ) u_div_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_u1_vld),
        .i_num({jcdu_pkg::DMG_ONE - r_u1_ctx.dmg_new, 24'd0}),
        .i_den(jcdu_pkg::DMG_ONE - r_u1_ctx.prior), .i_tag(r_u1_ctx),
        .o_valid(w_d3_vld), .o_quot(w_d3_q), .o_ovf(w_d3_ovf), .o_tag(w_d3_tag)
    );

    // result word
    logic              r_out_vld;
    jcdu_pkg::t_result r_out, n_out;

    always_comb begin
        n_out.new_damage   = w_d3_tag.dmg_in;
        n_out.stress_scale = jcdu_pkg::SCALE_ONE;
        n_out.failed       = 1'b0;
        n_out.eroded       = 1'b0;
        if (w_d3_tag.was_failed) begin
            n_out.failed = 1'b1;
        end else if (w_d3_tag.go) begin
            n_out.new_damage = w_d3_tag.dmg_new;
            if (w_d3_tag.prior < jcdu_pkg::DMG_ONE) begin
                n_out.stress_scale = w_d3_ovf ? jcdu_pkg::SCALE_MAX : w_d3_q;
            end
            n_out.failed = 31'(jcdu_pkg::DMG_ONE - w_d3_tag.dmg_new) <= r_epsilon;
            n_out.eroded = n_out.failed & r_erosion_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_q1_vld  <= 1'b0;
            r_q2_vld  <= 1'b0;
            r_t1_vld  <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_t3_vld  <= 1'b0;
            r_e1_vld  <= 1'b0;
            r_e2_vld  <= 1'b0;
            r_e3_vld  <= 1'b0;
            r_x1_vld  <= 1'b0;
            r_x2_vld  <= 1'b0;
            r_x3_vld  <= 1'b0;
            r_x4_vld  <= 1'b0;
            r_x5_vld  <= 1'b0;
            r_x6_vld  <= 1'b0;
            r_x7_vld  <= 1'b0;
            r_u1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start && !busy;
            r_q1_vld  <= r_in_vld;
            r_q2_vld  <= r_q1_vld;
            r_t1_vld  <= w_d1_vld;
            r_t2_vld  <= r_t1_vld;
            r_t3_vld  <= r_t2_vld;
            r_e1_vld  <= r_t3_vld;
            r_e2_vld  <= r_e1_vld;
            r_e3_vld  <= r_e2_vld;
            r_x1_vld  <= w_h_vld[HT];
            r_x2_vld  <= r_x1_vld;
            r_x3_vld  <= r_x2_vld;
            r_x4_vld  <= r_x3_vld;
            r_x5_vld  <= r_x4_vld;
            r_x6_vld  <= r_x5_vld;
            r_x7_vld  <= r_x6_vld;
            r_u1_vld  <= w_d2_vld;
            r_out_vld <= w_d3_vld;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule

[design/jcdu_checker.sv]
`timescale 1ns / 1ps

`include "johnson_cook_damage_update_assert.svh"

module jcdu_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input jcdu_pkg::t_item   i_item,
    input logic              busy,
    input logic              o_done,
    input jcdu_pkg::t_result o_result,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [2:0]        i_cfg_index,
    input logic [31:0]       i_cfg_data
);

    localparam int LAT = jcdu_pkg::LATENCY;

    `JCDU_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy, "busy raised")
    `JCDU_ASSERT_IMPL(a_done_after_start, i_clk, i_rst_n, o_done, $past(start && !busy, LAT), "result without matching word")
    `JCDU_ASSERT_IMPL(a_erode_needs_fail, i_clk, i_rst_n, o_done && o_result.eroded, o_result.failed, "eroded but not failed")
    `JCDU_ASSERT_IMPL(a_failed_passes, i_clk, i_rst_n, o_done && $past(i_item.already_failed, LAT), o_result.failed && !o_result.eroded && o_result.stress_scale == jcdu_pkg::SCALE_ONE, "failed word changed")

endmodule

bind johnson_cook_damage_update jcdu_checker u_jcdu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item), .busy(busy),
    .o_done(o_done), .o_result(o_result), .i_cfg_valid(i_cfg_valid),
    .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
);
